// ===== src/lfpid_pkg.sv =====
`default_nettype none
package lfpid_pkg;

   localparam int SAMPLE_BITS_DEF    = 10;
   localparam int GAIN_FRAC_BITS_DEF = 12;

   localparam int GAIN_W  = 16;
   localparam int OPA_W   = GAIN_W + 1;
   localparam int OPB_W   = 32;
   localparam int PROD_W  = OPA_W + OPB_W;
   localparam int ACC_W   = PROD_W + 3;
   localparam int ERR_W   = 18;
   localparam int DER_W   = ERR_W + 1;
   localparam int INT_W   = 32;
   localparam int PID_W   = 11;
   localparam int LR_W    = PID_W + 2;
   localparam int DUTY_W  = 8;
   localparam int TGT_W   = 10;
   localparam int BASE_W  = 7;
   localparam int PORT_W  = 16;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic signed [ERR_W-1:0]  ERR_MAX    = 18'sh1FFFF;
   localparam logic signed [ERR_W-1:0]  ERR_MIN    = -18'sh20000;
   localparam logic signed [PID_W-1:0]  PID_LIMIT  = 11'sd1000;
   localparam logic signed [DUTY_W-1:0] DUTY_LIMIT = 8'sd100;

   localparam logic [7:0] RED_MIN_R = 8'd200;
   localparam logic [7:0] RED_MAX_G = 8'd40;
   localparam logic [7:0] RED_MAX_B = 8'd30;
   localparam logic [7:0] YEL_MIN_R = 8'd200;
   localparam logic [7:0] YEL_MIN_G = 8'd150;
   localparam logic [7:0] YEL_MAX_B = 8'd40;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_RED    = 2'd1,
      EV_YELLOW = 2'd2
   } color_event_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TARGET_LEVEL = 3'd0,
      REG_PROP_GAIN    = 3'd1,
      REG_INTEG_GAIN   = 3'd2,
      REG_DERIV_GAIN   = 3'd3,
      REG_SUM_SCALE    = 3'd4,
      REG_BASE_SPEED   = 3'd5,
      REG_OWN_PORT     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TGT_W-1:0]  target_level;
      logic [GAIN_W-1:0] prop_gain;
      logic [GAIN_W-1:0] integ_gain;
      logic [GAIN_W-1:0] deriv_gain;
      logic [GAIN_W-1:0] sum_scale;
      logic [BASE_W-1:0] base_speed;
      logic [PORT_W-1:0] own_port;
   } cfg_type;

   typedef struct packed {
      logic mul_en;
      logic acc_load;
      logic acc_add;
   } mac_ctl_type;

endpackage
`default_nettype wire

// ===== src/lfpid_ifs.sv =====
`default_nettype none
interface lfpid_req_if #(
   parameter int SAMPLE_BITS = lfpid_pkg::SAMPLE_BITS_DEF
);
   logic                     valid;
   logic                     ready;
   logic [SAMPLE_BITS-1:0]   red_raw;
   logic [SAMPLE_BITS-1:0]   green_raw;
   logic [SAMPLE_BITS-1:0]   blue_raw;
   logic                     grant_flag;
   logic [lfpid_pkg::PORT_W-1:0] granted_port;

   modport source (output valid, red_raw, green_raw, blue_raw, grant_flag, granted_port,
                   input ready);
   modport sink   (input valid, red_raw, green_raw, blue_raw, grant_flag, granted_port,
                   output ready);
endinterface

interface lfpid_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [lfpid_pkg::DUTY_W-1:0] left_duty;
   logic signed [lfpid_pkg::DUTY_W-1:0] right_duty;
   logic                             mark_flag;
   logic                             stop_motors;
   logic [1:0]                       color_event;

   modport source (output valid, left_duty, right_duty, mark_flag, stop_motors, color_event,
                   input ready);
   modport sink   (input valid, left_duty, right_duty, mark_flag, stop_motors, color_event,
                   output ready);
endinterface
`default_nettype wire

// ===== src/lfpid_csr.sv =====
`default_nettype none
module lfpid_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [lfpid_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [lfpid_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output lfpid_pkg::cfg_type                       cfg_ff
);

   lfpid_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            lfpid_pkg::REG_TARGET_LEVEL: begin
               cfg_in.target_level = csr_wdata[lfpid_pkg::TGT_W-1:0];
            end
            lfpid_pkg::REG_PROP_GAIN: begin
               cfg_in.prop_gain = csr_wdata;
            end
            lfpid_pkg::REG_INTEG_GAIN: begin
               cfg_in.integ_gain = csr_wdata;
            end
            lfpid_pkg::REG_DERIV_GAIN: begin
               cfg_in.deriv_gain = csr_wdata;
            end
            lfpid_pkg::REG_SUM_SCALE: begin
               cfg_in.sum_scale = csr_wdata;
            end
            lfpid_pkg::REG_BASE_SPEED: begin
               cfg_in.base_speed = csr_wdata[lfpid_pkg::BASE_W-1:0];
            end
            lfpid_pkg::REG_OWN_PORT: begin
               cfg_in.own_port = csr_wdata;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_level <= 10'd60;
         cfg_ff.prop_gain    <= 16'd1638;
         cfg_ff.integ_gain   <= 16'd0;
         cfg_ff.deriv_gain   <= 16'd0;
         cfg_ff.sum_scale    <= 16'd410;
         cfg_ff.base_speed   <= 7'd30;
         cfg_ff.own_port     <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/lfpid_mac.sv =====
`default_nettype none
module lfpid_mac (
   input  wire logic                                   clock,
   input  wire lfpid_pkg::mac_ctl_type                 ctl,
   input  wire logic signed [lfpid_pkg::OPA_W-1:0]     op_a,
   input  wire logic signed [lfpid_pkg::OPB_W-1:0]     op_b,
   output logic signed [lfpid_pkg::PROD_W-1:0]         prod_ff,
   output logic signed [lfpid_pkg::ACC_W-1:0]          acc_ff
);

   logic signed [lfpid_pkg::PROD_W-1:0] prod_in;
   logic signed [lfpid_pkg::ACC_W-1:0]  acc_in;

   always_comb begin
      prod_in = op_a * op_b;
      acc_in  = acc_ff;
      if (ctl.acc_load) begin
         acc_in = lfpid_pkg::ACC_W'(prod_ff);
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + lfpid_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
   end

endmodule
`default_nettype wire

// ===== src/line_follow_pid_with_color_stop_core.sv =====
// Requests are taken only in IDLE; each passes through SCALE, ERR, MULP, MULI, MULD,
// SUM, FIN (which waits for the output register); a single 17x32 multiplier is used
// four times per item (brightness scale, then P, I and D products) under the sequencer.
// A response waiting in the output register does not block the next request.
// Reset is synchronous and active high; it restores the register defaults and clears
// the integral, the previous error, the red mark flag and all handshake state.
`default_nettype none
module line_follow_pid_with_color_stop_core #(
   parameter int SAMPLE_BITS    = lfpid_pkg::SAMPLE_BITS_DEF,
   parameter int GAIN_FRAC_BITS = lfpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   lfpid_req_if.sink                             req_ch,
   lfpid_rsp_if.source                           rsp_ch,
   input  wire logic                             csr_we,
   input  wire logic [lfpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lfpid_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W    = SAMPLE_BITS + 2;
   localparam int SCALED_W = lfpid_pkg::PROD_W - GAIN_FRAC_BITS;
   localparam int DIFF_W   = lfpid_pkg::PROD_W + 1;
   localparam int ERR_W    = lfpid_pkg::ERR_W;
   localparam int INT_W    = lfpid_pkg::INT_W;
   localparam int DER_W    = lfpid_pkg::DER_W;
   localparam int ACC_W    = lfpid_pkg::ACC_W;
   localparam int PID_W    = lfpid_pkg::PID_W;
   localparam int LR_W     = lfpid_pkg::LR_W;
   localparam int DUTY_W   = lfpid_pkg::DUTY_W;
   localparam int OPA_W    = lfpid_pkg::OPA_W;
   localparam int OPB_W    = lfpid_pkg::OPB_W;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_SCALE = 8'b0000_0010,
      ST_ERR   = 8'b0000_0100,
      ST_MULP  = 8'b0000_1000,
      ST_MULI  = 8'b0001_0000,
      ST_MULD  = 8'b0010_0000,
      ST_SUM   = 8'b0100_0000,
      ST_FIN   = 8'b1000_0000
   } state_type;

   lfpid_pkg::cfg_type     cfg;
   lfpid_pkg::mac_ctl_type mac_ctl;

   logic signed [OPA_W-1:0]              op_a;
   logic signed [OPB_W-1:0]              op_b;
   logic signed [lfpid_pkg::PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]              acc_ff;

   state_type                state_ff, state_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic signed [ERR_W-1:0]  prev_err_ff, prev_err_in;
   logic signed [INT_W-1:0]  integ_ff, integ_in;
   logic signed [DER_W-1:0]  deriv_ff, deriv_in;
   logic                     mark_ff, mark_in;
   logic                     stop_ff, stop_in;
   lfpid_pkg::color_event_type event_ff, event_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DUTY_W-1:0] left_ff, left_in;
   logic signed [DUTY_W-1:0] right_ff, right_in;
   logic                     out_mark_ff, out_mark_in;
   logic                     out_stop_ff, out_stop_in;
   logic [1:0]               out_event_ff, out_event_in;

   logic                     accept;
   logic                     red_hit;
   logic                     yel_hit;
   logic [SCALED_W-1:0]      scaled;
   logic signed [DIFF_W-1:0] diff;
   logic signed [ERR_W-1:0]  err_c;
   logic signed [INT_W:0]    isum;
   logic signed [ACC_W-1:0]  pid_wide;
   logic signed [PID_W-1:0]  pid_c;
   logic signed [LR_W-1:0]   left_w;
   logic signed [LR_W-1:0]   right_w;
   logic                     out_free;

   lfpid_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg_ff    (cfg)
   );

   lfpid_mac u_mac (
      .clock   (clock),
      .ctl     (mac_ctl),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff),
      .acc_ff  (acc_ff)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // Mark detection works on raw sample values.
   assign red_hit = (req_ch.red_raw >= SAMPLE_BITS'(lfpid_pkg::RED_MIN_R))
                 && (req_ch.green_raw <= SAMPLE_BITS'(lfpid_pkg::RED_MAX_G))
                 && (req_ch.blue_raw <= SAMPLE_BITS'(lfpid_pkg::RED_MAX_B));
   assign yel_hit = (req_ch.red_raw >= SAMPLE_BITS'(lfpid_pkg::YEL_MIN_R))
                 && (req_ch.green_raw > SAMPLE_BITS'(lfpid_pkg::YEL_MIN_G))
                 && (req_ch.blue_raw <= SAMPLE_BITS'(lfpid_pkg::YEL_MAX_B));

   // Error path: the scaled sum is never negative, so the low product bits drop off.
   always_comb begin
      scaled = prod_ff[lfpid_pkg::PROD_W-1:GAIN_FRAC_BITS];
      diff   = signed'(DIFF_W'(cfg.target_level)) - signed'(DIFF_W'(scaled));
      if (diff > DIFF_W'(lfpid_pkg::ERR_MAX)) begin
         err_c = lfpid_pkg::ERR_MAX;
      end else if (diff < DIFF_W'(lfpid_pkg::ERR_MIN)) begin
         err_c = lfpid_pkg::ERR_MIN;
      end else begin
         err_c = diff[ERR_W-1:0];
      end
      isum = (INT_W+1)'(integ_ff) + (INT_W+1)'(err_c);
   end

   // Output path: floor shift of the accumulated sum, then the two clamps.
   always_comb begin
      pid_wide = acc_ff >>> GAIN_FRAC_BITS;
      if (pid_wide > ACC_W'(lfpid_pkg::PID_LIMIT)) begin
         pid_c = lfpid_pkg::PID_LIMIT;
      end else if (pid_wide < -ACC_W'(lfpid_pkg::PID_LIMIT)) begin
         pid_c = -lfpid_pkg::PID_LIMIT;
      end else begin
         pid_c = pid_wide[PID_W-1:0];
      end
      left_w  = signed'(LR_W'(cfg.base_speed)) - LR_W'(pid_c);
      right_w = signed'(LR_W'(cfg.base_speed)) + LR_W'(pid_c);
      if (left_w > LR_W'(lfpid_pkg::DUTY_LIMIT)) begin
         left_in = lfpid_pkg::DUTY_LIMIT;
      end else if (left_w < -LR_W'(lfpid_pkg::DUTY_LIMIT)) begin
         left_in = -lfpid_pkg::DUTY_LIMIT;
      end else begin
         left_in = left_w[DUTY_W-1:0];
      end
      if (right_w > LR_W'(lfpid_pkg::DUTY_LIMIT)) begin
         right_in = lfpid_pkg::DUTY_LIMIT;
      end else if (right_w < -LR_W'(lfpid_pkg::DUTY_LIMIT)) begin
         right_in = -lfpid_pkg::DUTY_LIMIT;
      end else begin
         right_in = right_w[DUTY_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      err_in       = err_ff;
      prev_err_in  = prev_err_ff;
      integ_in     = integ_ff;
      deriv_in     = deriv_ff;
      mark_in      = mark_ff;
      stop_in      = stop_ff;
      event_in     = event_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_mark_in  = out_mark_ff;
      out_stop_in  = out_stop_ff;
      out_event_in = out_event_ff;
      mac_ctl      = '0;
      op_a         = '0;
      op_b         = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sum_in = SUM_W'(req_ch.red_raw) + SUM_W'(req_ch.green_raw)
                      + SUM_W'(req_ch.blue_raw);
               event_in = lfpid_pkg::EV_NONE;
               if (red_hit) begin
                  mark_in  = 1'b1;
                  event_in = lfpid_pkg::EV_RED;
               end
               if (yel_hit) begin
                  mark_in  = 1'b0;
                  event_in = lfpid_pkg::EV_YELLOW;
               end
               stop_in = !req_ch.grant_flag && mark_in
                      && (req_ch.granted_port == cfg.own_port);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = signed'({1'b0, cfg.sum_scale});
            op_b           = signed'(OPB_W'(sum_ff));
            state_in       = ST_ERR;
         end
         ST_ERR: begin
            err_in      = err_c;
            prev_err_in = err_c;
            deriv_in    = DER_W'(err_c) - DER_W'(prev_err_ff);
            if (isum[INT_W] != isum[INT_W-1]) begin
               integ_in = isum[INT_W] ? {1'b1, {(INT_W-1){1'b0}}}
                                      : {1'b0, {(INT_W-1){1'b1}}};
            end else begin
               integ_in = isum[INT_W-1:0];
            end
            state_in = ST_MULP;
         end
         ST_MULP: begin
            mac_ctl.mul_en = 1'b1;
            op_a           = signed'({1'b0, cfg.prop_gain});
            op_b           = OPB_W'(err_ff);
            state_in       = ST_MULI;
         end
         ST_MULI: begin
            mac_ctl.mul_en   = 1'b1;
            mac_ctl.acc_load = 1'b1;
            op_a             = signed'({1'b0, cfg.integ_gain});
            op_b             = OPB_W'(integ_ff);
            state_in         = ST_MULD;
         end
         ST_MULD: begin
            mac_ctl.mul_en  = 1'b1;
            mac_ctl.acc_add = 1'b1;
            op_a            = signed'({1'b0, cfg.deriv_gain});
            op_b            = OPB_W'(deriv_ff);
            state_in        = ST_SUM;
         end
         ST_SUM: begin
            mac_ctl.acc_add = 1'b1;
            state_in        = ST_FIN;
         end
         ST_FIN: begin
            // Hold here until the output register can take the new transaction.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_mark_in  = mark_ff;
               out_stop_in  = stop_ff;
               out_event_in = event_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_err_ff  <= '0;
         integ_ff     <= '0;
         mark_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_err_ff  <= prev_err_in;
         integ_ff     <= integ_in;
         mark_ff      <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff       <= sum_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      stop_ff      <= stop_in;
      event_ff     <= event_in;
      out_mark_ff  <= out_mark_in;
      out_stop_ff  <= out_stop_in;
      out_event_ff <= out_event_in;
      if (state_ff == ST_FIN && out_free) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.left_duty   = left_ff;
   assign rsp_ch.right_duty  = right_ff;
   assign rsp_ch.mark_flag   = out_mark_ff;
   assign rsp_ch.stop_motors = out_stop_ff;
   assign rsp_ch.color_event = out_event_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready)
      else $error("request accepted while a transaction is still in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == ST_FIN))
      else $error("pending response would be overwritten");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (left_ff <= lfpid_pkg::DUTY_LIMIT && left_ff >= -lfpid_pkg::DUTY_LIMIT
                     && right_ff <= lfpid_pkg::DUTY_LIMIT
                     && right_ff >= -lfpid_pkg::DUTY_LIMIT))
      else $error("motor duty outside the clamp range");

   a_stop_needs_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_stop_ff) |-> out_mark_ff)
      else $error("stop raised without the red mark flag");

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
module tb;

   localparam int HALF_PERIOD   = 10;
   localparam int SETTLE_CYCLES = 12;
   localparam int STALL_LIMIT   = 1000;
   localparam int MAX_IDLE      = 12;
   localparam int RAND_PHASES   = 8;
   localparam int PHASE_ITEMS   = 220;
   localparam int SOAK_ITEMS    = 200;
   localparam int REPORT_LIMIT  = 10;

   localparam int SAMPLE_BITS_DEF = lfpid_pkg::SAMPLE_BITS_DEF;
   localparam int PORT_W          = lfpid_pkg::PORT_W;
   localparam int DUTY_W          = lfpid_pkg::DUTY_W;
   localparam int CSR_IDX_W       = lfpid_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W      = lfpid_pkg::CSR_DATA_W;
   localparam int ERR_W           = lfpid_pkg::ERR_W;
   localparam int GAIN_W          = lfpid_pkg::GAIN_W;
   localparam int TGT_W           = lfpid_pkg::TGT_W;
   localparam int BASE_W          = lfpid_pkg::BASE_W;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam int     FRAC_BITS = 12;
   localparam longint ERR_HI    = 131071;
   localparam longint ERR_LO    = -131072;
   localparam longint INT_HI    = 64'sd2147483647;
   localparam longint INT_LO    = -64'sd2147483648;
   localparam longint PID_CAP   = 1000;
   localparam longint DUTY_CAP  = 100;

   localparam int RED_R_MIN   = 200;
   localparam int RED_G_MAX   = 40;
   localparam int RED_B_MAX   = 30;
   localparam int YEL_R_MIN   = 200;
   localparam int YEL_G_ABOVE = 150;
   localparam int YEL_B_MAX   = 40;

   typedef struct packed {
      logic [SAMPLE_BITS_DEF-1:0] red;
      logic [SAMPLE_BITS_DEF-1:0] green;
      logic [SAMPLE_BITS_DEF-1:0] blue;
      logic                       grant;
      logic [PORT_W-1:0]          port;
   } sample_type;

   typedef struct packed {
      logic signed [DUTY_W-1:0]   left_duty;
      logic signed [DUTY_W-1:0]   right_duty;
      logic                       mark_flag;
      logic                       stop_motors;
      lfpid_pkg::color_event_type color_event;
   } duty_result_type;

   typedef struct packed {
      logic                  is_cfg;
      logic [CSR_IDX_W-1:0]  reg_idx;
      logic [CSR_DATA_W-1:0] reg_val;
      sample_type            smp;
      logic                  pinned;
      duty_result_type       want;
   } stim_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lfpid_req_if req_ch ();
   lfpid_rsp_if rsp_ch ();

   line_follow_pid_with_color_stop_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the block's registers and controller state.
   lfpid_pkg::cfg_type      cfg_now;
   int                      integ_now;
   logic signed [ERR_W-1:0] err_prev;
   logic                    mark_now;

   duty_result_type duty_q[$];
   int unsigned  miss_count  = 0;
   int unsigned  idle_cycles = 0;
   bit           soak_mode   = 1'b0;
   bit           req_quiet   = 1'b0;
   bit           rsp_quiet   = 1'b0;
   int unsigned  req_run     = 0;
   int unsigned  rsp_run     = 0;

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic longint bound(input longint v, input longint lo, input longint hi);
      if (v < lo)
         return lo;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic duty_result_type steer_predict(input sample_type s);
      longint unsigned            bright;
      longint unsigned            scaled;
      longint                     err;
      longint                     integ;
      longint                     deriv;
      longint                     acc;
      longint                     pid;
      longint                     left;
      longint                     right;
      lfpid_pkg::color_event_type ev;
      duty_result_type            res;
      bright = 64'(s.red) + 64'(s.green) + 64'(s.blue);
      scaled = (64'(cfg_now.sum_scale) * bright) >> FRAC_BITS;
      if (scaled > 64'(cfg_now.target_level) + 64'd131072)
         err = ERR_LO;
      else
         err = bound(longint'(64'(cfg_now.target_level)) - longint'(scaled), ERR_LO, ERR_HI);
      integ = bound(longint'(integ_now) + err, INT_LO, INT_HI);
      deriv = err - longint'(err_prev);
      integ_now = int'(integ);
      err_prev = ERR_W'(err);
      acc = longint'(64'(cfg_now.prop_gain)) * err
          + longint'(64'(cfg_now.integ_gain)) * integ
          + longint'(64'(cfg_now.deriv_gain)) * deriv;
      // Arithmetic shift of a signed value rounds toward minus infinity.
      pid = bound(acc >>> FRAC_BITS, -PID_CAP, PID_CAP);
      left = bound(longint'(64'(cfg_now.base_speed)) - pid, -DUTY_CAP, DUTY_CAP);
      right = bound(longint'(64'(cfg_now.base_speed)) + pid, -DUTY_CAP, DUTY_CAP);
      ev = lfpid_pkg::EV_NONE;
      if (s.red >= RED_R_MIN && s.green <= RED_G_MAX && s.blue <= RED_B_MAX) begin
         mark_now = 1'b1;
         ev = lfpid_pkg::EV_RED;
      end
      if (s.red >= YEL_R_MIN && s.green > YEL_G_ABOVE && s.blue <= YEL_B_MAX) begin
         mark_now = 1'b0;
         ev = lfpid_pkg::EV_YELLOW;
      end
      res.left_duty = DUTY_W'(left);
      res.right_duty = DUTY_W'(right);
      res.mark_flag = mark_now;
      res.stop_motors = !s.grant && mark_now && (s.port == cfg_now.own_port);
      res.color_event = ev;
      return res;
   endfunction

   function automatic int unsigned idle_draw(input bit quiet);
      return (quiet || soak_mode) ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2, 3: return GAIN_W'($urandom_range(0, 8192));
         default: return GAIN_W'($urandom);
      endcase
   endfunction

   function automatic stim_row_type item_row(input int r, input int g, input int b,
                                             input bit gr, input int port);
      stim_row_type row;
      row = '0;
      row.smp.red = SAMPLE_BITS_DEF'(r);
      row.smp.green = SAMPLE_BITS_DEF'(g);
      row.smp.blue = SAMPLE_BITS_DEF'(b);
      row.smp.grant = gr;
      row.smp.port = PORT_W'(port);
      return row;
   endfunction

   function automatic stim_row_type pinned_row(input int r, input int g, input int b,
                                               input bit gr, input int port,
                                               input int left, input int right,
                                               input bit mark, input bit stop,
                                               input lfpid_pkg::color_event_type ev);
      stim_row_type row;
      row = item_row(r, g, b, gr, port);
      row.pinned = 1'b1;
      row.want.left_duty = DUTY_W'(left);
      row.want.right_duty = DUTY_W'(right);
      row.want.mark_flag = mark;
      row.want.stop_motors = stop;
      row.want.color_event = ev;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type row;
      row = '0;
      row.is_cfg = 1'b1;
      row.reg_idx = idx;
      row.reg_val = value;
      return row;
   endfunction

   task automatic note_miss(input string why, input duty_result_type want,
                            input duty_result_type got);
      miss_count++;
      if (miss_count <= REPORT_LIMIT) begin
         $display("%0t %s", $time, why);
         $display("   expected L=%0d R=%0d mark=%b stop=%b ev=%0d",
                  want.left_duty, want.right_duty, want.mark_flag,
                  want.stop_motors, want.color_event);
         $display("   actual   L=%0d R=%0d mark=%b stop=%b ev=%0d",
                  got.left_duty, got.right_duty, got.mark_flag,
                  got.stop_motors, got.color_event);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_sample(input sample_type s, input bit pinned,
                              input duty_result_type pinned_want);
      int unsigned     gap;
      duty_result_type want;
      if (req_run == 0) begin
         req_quiet = ($urandom_range(0, 3) == 0);
         req_run = $urandom_range(20, 80);
      end
      req_run--;
      gap = idle_draw(req_quiet);
      repeat (gap) begin
         req_ch.valid = 1'b0;
         {req_ch.red_raw, req_ch.green_raw, req_ch.blue_raw} = 30'($urandom);
         req_ch.grant_flag = 1'($urandom);
         req_ch.granted_port = 16'($urandom);
         @(negedge clock);
      end
      req_ch.red_raw = s.red;
      req_ch.green_raw = s.green;
      req_ch.blue_raw = s.blue;
      req_ch.grant_flag = s.grant;
      req_ch.granted_port = s.port;
      req_ch.valid = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      want = steer_predict(s);
      duty_q.push_back(pinned ? pinned_want : want);
      @(negedge clock);
   endtask

   task automatic settle_block();
      req_ch.valid = 1'b0;
      while (duty_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         lfpid_pkg::REG_TARGET_LEVEL: cfg_now.target_level = value[TGT_W-1:0];
         lfpid_pkg::REG_PROP_GAIN:    cfg_now.prop_gain = value[GAIN_W-1:0];
         lfpid_pkg::REG_INTEG_GAIN:   cfg_now.integ_gain = value[GAIN_W-1:0];
         lfpid_pkg::REG_DERIV_GAIN:   cfg_now.deriv_gain = value[GAIN_W-1:0];
         lfpid_pkg::REG_SUM_SCALE:    cfg_now.sum_scale = value[GAIN_W-1:0];
         lfpid_pkg::REG_BASE_SPEED:   cfg_now.base_speed = value[BASE_W-1:0];
         lfpid_pkg::REG_OWN_PORT:     cfg_now.own_port = value[PORT_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : duty_check
      duty_result_type got;
      duty_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.left_duty = rsp_ch.left_duty;
         got.right_duty = rsp_ch.right_duty;
         got.mark_flag = rsp_ch.mark_flag;
         got.stop_motors = rsp_ch.stop_motors;
         got.color_event = lfpid_pkg::color_event_type'(rsp_ch.color_event);
         if (duty_q.size() == 0) begin
            note_miss("response with nothing expected", '0, got);
         end else begin
            want = duty_q.pop_front();
            if (got.left_duty !== want.left_duty || got.right_duty !== want.right_duty ||
                got.mark_flag !== want.mark_flag || got.stop_motors !== want.stop_motors ||
                got.color_event !== want.color_event)
               note_miss("duty mismatch", want, got);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: ready may be held low for a random gap before each transaction.
   initial begin : rsp_drain
      int unsigned hold;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      @(negedge clock);
      forever begin
         if (rsp_run == 0) begin
            rsp_quiet = ($urandom_range(0, 3) == 0);
            rsp_run = $urandom_range(20, 80);
         end
         rsp_run--;
         hold = idle_draw(rsp_quiet);
         if (hold != 0) begin
            rsp_ch.ready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      stim_row_type          plan[$];
      sample_type            smp;
      int unsigned           phase;
      int unsigned           n;
      logic [TGT_W-1:0]      tgt;
      logic [GAIN_W-1:0]     pg;
      logic [GAIN_W-1:0]     ig;
      logic [GAIN_W-1:0]     dg;
      logic [GAIN_W-1:0]     sc;
      logic [BASE_W-1:0]     bs;
      logic [PORT_W-1:0]     port;

      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.red_raw = '0;
      req_ch.green_raw = '0;
      req_ch.blue_raw = '0;
      req_ch.grant_flag = 1'b0;
      req_ch.granted_port = '0;

      cfg_now.target_level = 10'd60;
      cfg_now.prop_gain = 16'd1638;
      cfg_now.integ_gain = '0;
      cfg_now.deriv_gain = '0;
      cfg_now.sum_scale = 16'd410;
      cfg_now.base_speed = 7'd30;
      cfg_now.own_port = '0;
      integ_now = 0;
      err_prev = '0;
      mark_now = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Register defaults: dark sample gives an error equal to the setpoint.
      plan.push_back(pinned_row(0, 0, 0, 1, 0, 7, 53, 0, 0, lfpid_pkg::EV_NONE));
      plan.push_back(item_row(1023, 1023, 1023, 0, 16'hFFFF));
      plan.push_back(item_row(200, 40, 30, 1, 0));
      plan.push_back(item_row(250, 0, 0, 0, 0));
      plan.push_back(item_row(300, 10, 20, 0, 5));
      plan.push_back(item_row(200, 151, 40, 0, 0));
      plan.push_back(item_row(199, 0, 0, 0, 0));
      plan.push_back(item_row(200, 41, 0, 1, 0));
      plan.push_back(item_row(200, 0, 31, 0, 0));
      plan.push_back(item_row(200, 150, 40, 0, 0));
      plan.push_back(item_row(200, 200, 41, 0, 0));
      // No correction and a base speed above the limit: both duties clamp.
      plan.push_back(cfg_row(lfpid_pkg::REG_PROP_GAIN, 16'd0));
      plan.push_back(cfg_row(lfpid_pkg::REG_BASE_SPEED, 16'd127));
      plan.push_back(pinned_row(0, 0, 0, 1, 0, 100, 100, 0, 0, lfpid_pkg::EV_NONE));
      plan.push_back(pinned_row(1023, 0, 0, 0, 0, 100, 100, 1, 1, lfpid_pkg::EV_RED));
      plan.push_back(pinned_row(512, 1023, 0, 0, 0, 100, 100, 0, 0, lfpid_pkg::EV_YELLOW));
      plan.push_back(cfg_row(lfpid_pkg::REG_BASE_SPEED, 16'd0));
      plan.push_back(pinned_row(1023, 1023, 1023, 1, 16'hFFFF, 0, 0, 0, 0,
                                lfpid_pkg::EV_NONE));
      plan.push_back(cfg_row(lfpid_pkg::REG_OWN_PORT, 16'hFFFF));
      plan.push_back(cfg_row(REG_UNUSED, 16'h1234));
      plan.push_back(pinned_row(220, 5, 5, 0, 16'hFFFF, 0, 0, 1, 1, lfpid_pkg::EV_RED));
      plan.push_back(pinned_row(220, 5, 5, 1, 16'hFFFF, 0, 0, 1, 0, lfpid_pkg::EV_RED));
      plan.push_back(cfg_row(lfpid_pkg::REG_TARGET_LEVEL, 16'd1023));
      plan.push_back(cfg_row(lfpid_pkg::REG_SUM_SCALE, 16'hFFFF));
      plan.push_back(cfg_row(lfpid_pkg::REG_PROP_GAIN, 16'hFFFF));
      plan.push_back(cfg_row(lfpid_pkg::REG_INTEG_GAIN, 16'hFFFF));
      plan.push_back(cfg_row(lfpid_pkg::REG_DERIV_GAIN, 16'hFFFF));
      plan.push_back(cfg_row(lfpid_pkg::REG_BASE_SPEED, 16'd100));
      plan.push_back(item_row(0, 0, 0, 1, 0));
      plan.push_back(item_row(1023, 1023, 1023, 0, 16'hFFFF));
      plan.push_back(item_row(0, 0, 0, 0, 16'hFFFF));
      plan.push_back(item_row(1023, 1023, 1023, 1, 0));
      plan.push_back(cfg_row(lfpid_pkg::REG_SUM_SCALE, 16'd0));
      plan.push_back(item_row(1023, 512, 7, 0, 16'hFFFF));
      plan.push_back(item_row(3, 900, 1023, 1, 16'h8000));

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            settle_block();
            write_reg(plan[i].reg_idx, plan[i].reg_val);
         end else begin
            send_sample(plan[i].smp, plan[i].pinned, plan[i].want);
         end
      end

      for (phase = 0; phase < RAND_PHASES; phase++) begin
         settle_block();
         if (phase == 0) begin
            tgt = '0;
            pg = '0;
            ig = '0;
            dg = '0;
            sc = '0;
            bs = '0;
            port = '0;
         end else if (phase == 1) begin
            tgt = '1;
            pg = '1;
            ig = '1;
            dg = '1;
            sc = '1;
            bs = '1;
            port = '1;
         end else begin
            tgt = TGT_W'($urandom_range(0, 1023));
            pg = pick_gain();
            ig = pick_gain();
            dg = pick_gain();
            case ($urandom_range(0, 4))
               0: sc = '0;
               1: sc = '1;
               2, 3: sc = GAIN_W'($urandom_range(100, 2000));
               default: sc = GAIN_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0: bs = '0;
               1: bs = 7'd100;
               2: bs = '1;
               default: bs = BASE_W'($urandom);
            endcase
            port = ($urandom_range(0, 3) == 0) ? '0 : PORT_W'($urandom);
         end
         // Upper data bits beyond a register's width must be dropped by the block.
         write_reg(lfpid_pkg::REG_TARGET_LEVEL, {6'($urandom), tgt});
         write_reg(lfpid_pkg::REG_PROP_GAIN, pg);
         write_reg(lfpid_pkg::REG_INTEG_GAIN, ig);
         write_reg(lfpid_pkg::REG_DERIV_GAIN, dg);
         write_reg(lfpid_pkg::REG_SUM_SCALE, sc);
         write_reg(lfpid_pkg::REG_BASE_SPEED, {9'($urandom), bs});
         write_reg(lfpid_pkg::REG_OWN_PORT, port);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2: begin
                  smp.red = SAMPLE_BITS_DEF'($urandom_range(190, 1023));
                  smp.green = SAMPLE_BITS_DEF'($urandom_range(0, 50));
                  smp.blue = SAMPLE_BITS_DEF'($urandom_range(0, 40));
               end
               3, 4: begin
                  smp.red = SAMPLE_BITS_DEF'($urandom_range(190, 1023));
                  smp.green = SAMPLE_BITS_DEF'($urandom_range(140, 1023));
                  smp.blue = SAMPLE_BITS_DEF'($urandom_range(0, 50));
               end
               default: begin
                  smp.red = SAMPLE_BITS_DEF'($urandom);
                  smp.green = SAMPLE_BITS_DEF'($urandom);
                  smp.blue = SAMPLE_BITS_DEF'($urandom);
               end
            endcase
            smp.grant = 1'($urandom);
            smp.port = ($urandom_range(0, 1) == 0) ? cfg_now.own_port : PORT_W'($urandom);
            send_sample(smp, 1'b0, '0);
         end
      end

      // Run of the most negative reachable error, back to back, to push the
      // integral far below zero.
      settle_block();
      write_reg(lfpid_pkg::REG_TARGET_LEVEL, 16'd0);
      write_reg(lfpid_pkg::REG_SUM_SCALE, 16'hFFFF);
      write_reg(lfpid_pkg::REG_PROP_GAIN, 16'd0);
      write_reg(lfpid_pkg::REG_INTEG_GAIN, 16'd1);
      write_reg(lfpid_pkg::REG_DERIV_GAIN, 16'd0);
      write_reg(lfpid_pkg::REG_BASE_SPEED, 16'd50);
      soak_mode = 1'b1;
      for (n = 0; n < SOAK_ITEMS; n++) begin
         smp.red = '1;
         smp.green = '1;
         smp.blue = '1;
         smp.grant = 1'($urandom);
         smp.port = ($urandom_range(0, 1) == 0) ? cfg_now.own_port : PORT_W'($urandom);
         send_sample(smp, 1'b0, '0);
      end
      soak_mode = 1'b0;

      settle_block();
      if (miss_count == 0 && duty_q.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== line_follow_pid_with_color_stop_core.f =====
src/lfpid_pkg.sv
src/lfpid_ifs.sv
src/lfpid_csr.sv
src/lfpid_mac.sv
src/line_follow_pid_with_color_stop_core.sv
test/tb.sv
